// ===== sv/uti_pkg.sv =====
// ----------------------------------------------------------------------------
// uti_pkg
// Shared constants, types and a saturation function for the upper triangular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none
package uti_pkg;
    localparam int MAX_SIZE  = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic [0:0] KIND_LOAD   = 1'b0;
    localparam logic [0:0] KIND_INVERT = 1'b1;

    typedef logic signed [DATA_W-1:0] t_word;

    function automatic t_word sat32(input logic signed [65:0] x);
        if (x > 66'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -66'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/uti_ram.sv =====
// ----------------------------------------------------------------------------
// uti_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module uti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== sv/uti_recip.sv =====
// ----------------------------------------------------------------------------
// uti_recip
// Bit-serial reciprocal 2^32/|d|, rounded half up, signed and saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module uti_recip import uti_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_start,
    input  t_word  i_d,
    output logic   o_done,
    output t_word  o_recip
);
    logic [33:0] r_num;
    logic [33:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_mag;
    logic        r_neg, r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] w_mag;
    logic [33:0] w_trial, w_div, w_diff;
    logic        w_ge;

    // (2^33 + mag) / (2*mag) gives the round-half-up quotient
    assign w_mag   = i_d[31] ? 32'(-i_d) : 32'(i_d);
    assign w_trial = {r_rem, r_num[33]};
    assign w_div   = {1'b0, r_mag, 1'b0};
    assign w_ge    = w_trial >= w_div;
    assign w_diff  = w_trial - w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_d[31];
                r_mag  <= w_mag;
                r_num  <= {2'b10, w_mag};
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[32:0] : w_trial[32:0];
                r_num <= {r_num[32:0], 1'b0};
                r_quo <= {r_quo[32:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd33) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (!r_neg) begin
            if (r_quo > 34'h0_7FFF_FFFF) begin
                o_recip = 32'sh7FFF_FFFF;
            end else begin
                o_recip = t_word'(r_quo[31:0]);
            end
        end else begin
            if (r_quo >= 34'h0_8000_0000) begin
                o_recip = 32'sh8000_0000;
            end else begin
                o_recip = t_word'(-r_quo[31:0]);
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/upper_triangular_inverse_top.sv =====
// An invert word takes each column through the diagonal read and serial
// reciprocal, multiply-adds of the n^3/6 inner products (RDA, RDB, MUL, ACC)
// and off-diagonal scales (RDX, SMUL, SWR), all on one shared 32x32 multiplier;
// n(n+1)/2 result words follow, each read out and held until it is taken.
// Load words are taken one per cycle while idle. Reset is synchronous, active
// low; the matrix store is not cleared, size resets to 8 and the fault flag to 0.
// ----------------------------------------------------------------------------
// upper_triangular_inverse_top
// Column-wise Q16.16 upper triangular inverse with a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module upper_triangular_inverse_top import uti_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // row_index, col_index, element_value, pad
    input  wire         s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_row, out_col, out_value, pad
    output logic        m_axis_tlast,  // last
    output logic        m_axis_tuser,  // zero_pivot
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [3:0]  i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_DIAG = 4'd1, S_DIVW = 4'd2,
        S_RDA = 4'd3, S_RDB = 4'd4, S_MUL = 4'd5, S_ACC = 4'd6,
        S_RDX = 4'd7, S_SMUL = 4'd8, S_SWR = 4'd9, S_DWR = 4'd10,
        S_ORD = 4'd11, S_OWAIT = 4'd12, S_OUT = 4'd13, S_DRD = 4'd14;

    logic [3:0]  r_st;
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0] r_n1, r_i, r_j, r_k;
    logic        r_fault, r_last;
    t_word       r_a, r_r;
    logic signed [65:0] r_sum;
    logic signed [63:0] r_prod;
    t_word       r_scr [MAX_SIZE];

    logic        w_we;
    logic [ADDR_W-1:0] w_addr;
    t_word       w_wd, w_rd;
    logic        w_rstart, w_rdone;
    t_word       w_recip;
    logic [IDX_W-1:0] w_row, w_col;
    logic signed [63:0] w_rnd;
    t_word       w_ma, w_mb;
    logic signed [63:0] w_mprod;

    uti_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE*MAX_SIZE)) u_store (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd));
    uti_recip u_recip (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_rstart),
        .i_d(w_rd), .o_done(w_rdone), .o_recip(w_recip));

    assign w_row = s_axis_tdata[2:0];
    assign w_col = s_axis_tdata[5:3];
    assign s_axis_tready = r_st == S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign w_rnd = (r_prod + 64'sd32768) >>> 16;
    assign w_rstart = r_st == S_DRD;

    // shared multiplier: dot-product terms, then r times scratch (negated after)
    assign w_ma = (r_st == S_RDX) ? r_r : r_a;
    assign w_mb = (r_st == S_RDX) ? r_scr[r_i] : w_rd;
    assign w_mprod = 64'(w_ma) * 64'(w_mb);

    always_comb begin
        w_we = 1'b0;
        w_addr = {r_i, r_j};
        w_wd = w_rd;
        case (r_st)
            S_IDLE: begin
                w_addr = {w_row, w_col};
                w_wd = s_axis_tdata[37:6];
                w_we = s_axis_tvalid && s_axis_tuser == KIND_LOAD && w_row <= w_col;
            end
            S_DIAG, S_DRD, S_DIVW: w_addr = {r_j, r_j};
            S_RDA: w_addr = {r_i, r_k};
            S_RDB, S_MUL: w_addr = {r_k, r_j};
            S_SWR: begin
                w_we = 1'b1;
                w_wd = sat32(66'(w_rnd));
            end
            S_DWR: begin
                w_addr = {r_j, r_j};
                w_we = 1'b1;
                w_wd = r_r;
            end
            default: w_addr = {r_i, r_j};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_size <= SIZE_RESET;
            r_fault <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tuser == KIND_INVERT) begin
                    r_fault <= 1'b0;
                    r_n1 <= r_size == 4'd0 ? 3'd0 : r_size > 4'd8 ? 3'd7 : 3'(r_size - 4'd1);
                    r_j <= '0;
                    r_st <= S_DIAG;
                end
                S_DIAG: r_st <= S_DRD;
                S_DRD: r_st <= S_DIVW;
                S_DIVW: if (w_rdone) begin
                    r_r <= w_recip;
                    if (w_rd == '0) begin
                        r_fault <= 1'b1;
                        r_r <= 32'sh7FFF_FFFF;
                    end
                    r_i <= '0;
                    r_k <= '0;
                    r_sum <= '0;
                    r_st <= r_j == '0 ? S_DWR : S_RDA;
                end
                S_RDA: r_st <= S_RDB;
                S_RDB: begin
                    r_a <= w_rd;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= w_mprod;
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_k == r_j - 3'd1) begin
                        r_scr[r_i] <= sat32(r_sum + 66'(w_rnd));
                        r_sum <= '0;
                        if (r_i == r_j - 3'd1) begin
                            r_i <= '0;
                            r_st <= S_RDX;
                        end else begin
                            r_i <= r_i + 3'd1;
                            r_k <= r_i + 3'd1;
                            r_st <= S_RDA;
                        end
                    end else begin
                        r_sum <= r_sum + 66'(w_rnd);
                        r_k <= r_k + 3'd1;
                        r_st <= S_RDA;
                    end
                end
                S_RDX: begin
                    r_prod <= w_mprod;
                    r_st <= S_SMUL;
                end
                S_SMUL: begin
                    r_prod <= -r_prod;
                    r_st <= S_SWR;
                end
                S_SWR: if (r_i == r_j - 3'd1) begin
                    r_st <= S_DWR;
                end else begin
                    r_i <= r_i + 3'd1;
                    r_st <= S_RDX;
                end
                S_DWR: if (r_j == r_n1) begin
                    r_i <= '0;
                    r_j <= '0;
                    r_st <= S_ORD;
                end else begin
                    r_j <= r_j + 3'd1;
                    r_st <= S_DIAG;
                end
                S_ORD: r_st <= S_OWAIT;
                S_OWAIT: begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata <= {2'b00, w_rd, r_j, r_i};
                    m_axis_tlast <= r_i == r_n1 && r_j == r_n1;
                    m_axis_tuser <= r_fault;
                    r_last <= r_i == r_n1 && r_j == r_n1;
                    r_st <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    m_axis_tvalid <= 1'b0;
                    if (r_last) begin
                        r_st <= S_IDLE;
                    end else begin
                        if (r_j == r_n1) begin
                            r_i <= r_i + 3'd1;
                            r_j <= r_i + 3'd1;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                        r_st <= S_ORD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/uti_checker.sv =====
// ----------------------------------------------------------------------------
// uti_checker
// Port-level checks for the upper triangular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none
module uti_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken during readout");
    a_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= m_axis_tdata[5:3])
        else $error("result below diagonal");
    a_lastdiag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == m_axis_tdata[5:3])
        else $error("last not on diagonal");
endmodule

bind upper_triangular_inverse_top uti_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));
`default_nettype wire
